>>> design/tmwf_pkg.sv
`timescale 1ns / 1ps

package tmwf_pkg;

  // window geometry
  localparam int WINDOW     = 10;
  localparam int MEAN_SHIFT = 3;

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 24;
  localparam int OFFSET_W = 32;
  localparam int UV_W     = 32;
  localparam int Q_SHIFT  = 16;

  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
  localparam int PROD_W = SAMPLE_W + GAIN_W;
  // product plus sign-extended offset, one guard bit and one sign bit
  localparam int TOTAL_W = PROD_W + 2;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  // configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [0:0] REG_GAIN   = 1'b0;
  localparam logic [0:0] REG_OFFSET = 1'b1;

  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 24'd63989;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 32'd15433728;

  // controller to datapath commands
  typedef struct packed {
    logic             wr_sample;
    logic             scan_en;
    logic             scan_first;
    logic [IDX_W-1:0] scan_idx;
    logic             trim_en;
    logic             mul_en;
    logic             out_load;
  } tmwf_cmd_t;

endpackage

>>> design/tmwf_ctrl.sv
`timescale 1ns / 1ps

module tmwf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tmwf_pkg::tmwf_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_TRIM = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam logic [tmwf_pkg::IDX_W-1:0] LAST_IDX =
    tmwf_pkg::IDX_W'(tmwf_pkg::WINDOW - 1);

  logic [2:0]                 state;
  logic [2:0]                 state_next;
  logic [tmwf_pkg::IDX_W-1:0] idx;
  logic [tmwf_pkg::IDX_W-1:0] idx_next;
  logic                       out_free;
  logic                       accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  // output register can take a new result
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    unique case (state)
      S_IDLE: begin
        idx_next = '0;
        if (accept) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx == LAST_IDX) begin
          state_next = S_TRIM;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_TRIM: state_next = S_MUL;
      S_MUL:  state_next = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.wr_sample  = accept;
    cmd.scan_en    = (state == S_SCAN);
    cmd.scan_first = (state == S_SCAN) && (idx == '0);
    cmd.scan_idx   = idx;
    cmd.trim_en    = (state == S_TRIM);
    cmd.mul_en     = (state == S_MUL);
    cmd.out_load   = (state == S_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> design/tmwf_dp.sv
`timescale 1ns / 1ps

module tmwf_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tmwf_pkg::tmwf_cmd_t                  cmd,
  input  logic [tmwf_pkg::SAMPLE_W-1:0]        sample,
  input  logic [tmwf_pkg::GAIN_W-1:0]          gain_q16,
  input  logic signed [tmwf_pkg::OFFSET_W-1:0] offset_q16,
  output logic [tmwf_pkg::SAMPLE_W-1:0]        mean_code,
  output logic [tmwf_pkg::UV_W-1:0]            microvolts
);

  localparam logic [tmwf_pkg::IDX_W-1:0] LAST_IDX =
    tmwf_pkg::IDX_W'(tmwf_pkg::WINDOW - 1);

  logic [tmwf_pkg::SAMPLE_W-1:0] window [tmwf_pkg::WINDOW];
  logic [tmwf_pkg::IDX_W-1:0]    slot;

  logic [tmwf_pkg::SUM_W-1:0]    sum;
  logic [tmwf_pkg::SAMPLE_W-1:0] hi;
  logic [tmwf_pkg::SAMPLE_W-1:0] lo;
  logic [tmwf_pkg::SAMPLE_W-1:0] mean;
  logic [tmwf_pkg::PROD_W-1:0]   prod;

  logic [tmwf_pkg::SAMPLE_W-1:0]       rd;
  logic [tmwf_pkg::SUM_W-1:0]          trimmed;
  logic [tmwf_pkg::SUM_W-1:0]          shifted;
  logic [tmwf_pkg::SAMPLE_W-1:0]       mean_next;
  logic signed [tmwf_pkg::TOTAL_W-1:0] total;
  logic [tmwf_pkg::UV_W-1:0]           uv_next;

  assign rd = window[cmd.scan_idx];

  // sum never underflows: it contains both extremes
  assign trimmed   = sum - tmwf_pkg::SUM_W'(hi) - tmwf_pkg::SUM_W'(lo);
  assign shifted   = trimmed >> tmwf_pkg::MEAN_SHIFT;
  assign mean_next = (shifted > tmwf_pkg::SUM_W'(tmwf_pkg::SAMPLE_MAX)) ?
                     tmwf_pkg::SAMPLE_MAX : shifted[tmwf_pkg::SAMPLE_W-1:0];

  assign total = $signed({2'b00, prod}) +
                 tmwf_pkg::TOTAL_W'(offset_q16);

  // clamp at zero and at the top of the 32-bit range
  always_comb begin
    if (total[tmwf_pkg::TOTAL_W-1]) begin
      uv_next = '0;
    end else if (total[tmwf_pkg::TOTAL_W-2]) begin
      uv_next = '1;
    end else begin
      uv_next = total[tmwf_pkg::Q_SHIFT +: tmwf_pkg::UV_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      for (int k = 0; k < tmwf_pkg::WINDOW; k++) begin
        window[k] <= '0;
      end
    end else if (cmd.wr_sample) begin
      window[slot] <= sample;
      slot         <= (slot >= LAST_IDX) ? '0 : slot + 1'b1;
    end
  end

  // one stored sample per cycle through the running sum, max and min
  always_ff @(posedge clk) begin
    if (cmd.scan_en) begin
      if (cmd.scan_first) begin
        sum <= tmwf_pkg::SUM_W'(rd);
        hi  <= rd;
        lo  <= rd;
      end else begin
        sum <= sum + tmwf_pkg::SUM_W'(rd);
        if (rd > hi) begin
          hi <= rd;
        end
        if (rd < lo) begin
          lo <= rd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.trim_en) begin
      mean <= mean_next;
    end
    if (cmd.mul_en) begin
      prod <= mean * gain_q16;
    end
    if (cmd.out_load) begin
      mean_code  <= mean;
      microvolts <= uv_next;
    end
  end

endmodule

>>> design/trimmed_mean_window_filter.sv
`timescale 1ns / 1ps

// trimmed mean window filter: every accepted sample overwrites the oldest of
// ten stored samples (all zero after reset, and those zeros count until
// overwritten), then the window is scanned one stored sample per cycle through
// a single read port for the sum, the largest and the smallest value; one of
// each extreme is dropped, the rest is shifted right by three (saturating at
// 24 bits) to give mean_code, and microvolts = (mean * gain_q16 + offset_q16)
// >> 16, clamped to 0 .. 2^32-1. one sample is in work at a time: after
// acceptance it passes through the scan of every stored sample, trim,
// multiply, and offset and clamp before the next can be accepted, and it
// waits longer only while the previous result still sits stalled in the output
// register. registers: gain_q16 at byte address 0 (unsigned q16, reset 63989)
// and offset_q16 at byte address 4 (signed q16, reset 15433728); write them
// only while no transaction is in flight.
module trimmed_mean_window_filter (
  input  logic                                clk,
  input  logic                                rst,
  // sample channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tmwf_pkg::SAMPLE_W-1:0]       sample,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tmwf_pkg::SAMPLE_W-1:0]       mean_code,
  output logic [tmwf_pkg::UV_W-1:0]           microvolts,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tmwf_pkg::ADDR_W-1:0]         paddr,
  input  logic [tmwf_pkg::DATA_W-1:0]         pwdata,
  output logic [tmwf_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  tmwf_pkg::tmwf_cmd_t cmd;

  logic [tmwf_pkg::GAIN_W-1:0]          gain_q16;
  logic signed [tmwf_pkg::OFFSET_W-1:0] offset_q16;
  logic [0:0]                           reg_idx;
  logic                                 reg_wr;

  // registers sit on 4-byte boundaries, no wait states
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_q16   <= tmwf_pkg::GAIN_RESET;
      offset_q16 <= tmwf_pkg::OFFSET_RESET;
    end else if (reg_wr) begin
      unique case (reg_idx)
        tmwf_pkg::REG_GAIN:   gain_q16   <= pwdata[tmwf_pkg::GAIN_W-1:0];
        tmwf_pkg::REG_OFFSET: offset_q16 <= pwdata[tmwf_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // read back; gain is zero-extended
  always_comb begin
    unique case (reg_idx)
      tmwf_pkg::REG_GAIN:   prdata = tmwf_pkg::DATA_W'(gain_q16);
      tmwf_pkg::REG_OFFSET: prdata = offset_q16;
      default:              prdata = '0;
    endcase
  end

  // sequencer: accept, scan, trim, multiply, finish
  tmwf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // sample window, scan accumulators, scaling and result register
  tmwf_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sample     (sample),
    .gain_q16   (gain_q16),
    .offset_q16 (offset_q16),
    .mean_code  (mean_code),
    .microvolts (microvolts)
  );

  // an accepted transaction keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an accepted transaction");

  // the scan starts right after a transaction is accepted
  a_scan_follows_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_first |-> $past(in_valid && !in_stall))
    else $error("window scan started without an accepted transaction");

  // a loaded result is presented on the next cycle
  a_load_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("result loaded but not presented");

  // results are never loaded during the scan
  a_no_load_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_en |-> !cmd.out_load)
    else $error("result loaded while the window scan is running");

endmodule
